// ===== hw/rtl/mio0_pkg.sv =====
// ----------------------------------------------------------------------------
// mio0_pkg
// Shared types, codes and defaults for the MIO0 token decompressor.
// ----------------------------------------------------------------------------
package mio0_pkg;

   localparam int HIST_DEPTH_DEF  = 4096;
   localparam int COUNT_WIDTH_DEF = 24;
   localparam int CFG_W           = 24;
   localparam int RUN_W           = 5;
   localparam int DIST_W          = 13;

   // token kinds, also used for the wanted kind
   localparam logic [1:0] FN_MAP  = 2'd0;
   localparam logic [1:0] FN_LIT  = 2'd1;
   localparam logic [1:0] FN_WORD = 2'd2;
   localparam logic [1:0] FN_NONE = 2'd3;

   // frame status codes
   localparam logic [2:0] ST_RUN     = 3'd0;
   localparam logic [2:0] ST_DONE    = 3'd1;
   localparam logic [2:0] ST_DIST    = 3'd2;
   localparam logic [2:0] ST_OVERRUN = 3'd3;
   localparam logic [2:0] ST_WRONG   = 3'd4;

   // register indexes
   localparam logic [1:0] REG_OUTPUT_SIZE    = 2'd0;
   localparam logic [1:0] REG_PAIR_OFFSET    = 2'd1;
   localparam logic [1:0] REG_LITERAL_OFFSET = 2'd2;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] token_data;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       last_of_run;
      logic [1:0] next_want;
      logic [2:0] status;
   } rsp_item_type;

   typedef struct packed {
      logic load;
      logic eval;
      logic commit;
      logic emit;
      logic rd_issue;
      logic consume;
   } dp_cmd_type;

   typedef struct packed {
      logic is_copy;
      logic out_free;
      logic pend;
      logic rd_more;
      logic wr_last;
   } dp_sts_type;

endpackage

// ===== hw/rtl/mio0_lz_decompressor.sv =====
// ----------------------------------------------------------------------------
// mio0_lz_decompressor
// MIO0 back-end decompressor fed by a stream of map, literal and
// back-reference tokens.
// ----------------------------------------------------------------------------
// Each accepted item is one token; next_want in every result tells the reader
// which kind to send next. A map byte, a literal, or any token that is refused
// or arrives after the frame has stopped passes through accept, two evaluate
// steps and one result. A back-reference that copies n bytes streams them
// out of the history memory: it has one registered read port, one read is kept
// ahead of the write, and one byte per cycle leaves through the output register
// while the result side is free, up to a full 18-byte run. A stalled result
// side holds the copy in place. Configuration is written through the csr_ port
// while the block is idle; offsets written after the first token only change
// the register.
module mio0_lz_decompressor
   import mio0_pkg::*;
#(
   parameter int HISTORY_DEPTH = HIST_DEPTH_DEF,
   parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_item_type     req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_item_type     rsp_payload,
   input  logic             csr_write_en,
   input  logic [1:0]       csr_index,
   input  logic [CFG_W-1:0] csr_wdata
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   mio0_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mio0_dp #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .COUNT_WIDTH   (COUNT_WIDTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_payload  (req_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload)
   );

endmodule

// ===== hw/rtl/mio0_ctrl.sv =====
// ----------------------------------------------------------------------------
// mio0_ctrl
// Sequencer: takes a token, runs the two evaluate steps, then emits a single
// item or streams a back-reference copy out of the history memory.
// ----------------------------------------------------------------------------
module mio0_ctrl
   import mio0_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EVAL   = 3'd1;
   localparam logic [2:0] S_COMMIT = 3'd2;
   localparam logic [2:0] S_EMIT   = 3'd3;
   localparam logic [2:0] S_COPY   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = sts.is_copy ? S_COPY : S_EMIT;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_COPY: begin
            // one read kept ahead of the byte being written out
            cmd.consume  = sts.pend && sts.out_free;
            cmd.rd_issue = sts.rd_more && (!sts.pend || cmd.consume);
            if (cmd.consume && sts.wr_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/mio0_dp.sv =====
// ----------------------------------------------------------------------------
// mio0_dp
// Datapath: configuration, frame state, history memory, copy pointers and
// the output register.
// ----------------------------------------------------------------------------
module mio0_dp
   import mio0_pkg::*;
#(
   parameter int HISTORY_DEPTH = HIST_DEPTH_DEF,
   parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  req_item_type req_payload,
   input  logic         csr_write_en,
   input  logic [1:0]   csr_index,
   input  logic [CFG_W-1:0] csr_wdata,
   input  dp_cmd_type   cmd,
   output dp_sts_type   sts,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_payload
);

   localparam int AW   = $clog2(HISTORY_DEPTH);
   localparam int PW   = AW + 1;
   localparam int WIDE = ((COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W) + 1;
   localparam logic [PW-1:0]   DEPTH_P   = PW'(HISTORY_DEPTH);
   localparam logic [AW-1:0]   LAST_ADDR = AW'(HISTORY_DEPTH - 1);
   localparam logic [WIDE-1:0] CNT_SPAN  = WIDE'(1) << COUNT_WIDTH;

   // configuration
   logic [CFG_W-1:0] osize_ff, osize_in;
   logic [CFG_W-1:0] pair_off_ff, pair_off_in;
   logic [CFG_W-1:0] lit_off_ff, lit_off_in;

   // frame state
   logic [COUNT_WIDTH-1:0] prod_ff, prod_in;
   logic [7:0]       map_bits_ff, map_bits_in;
   logic [7:0]       bsel_ff, bsel_in;
   logic [CFG_W-1:0] map_pos_ff, map_pos_in;
   logic [CFG_W-1:0] pair_pos_ff, pair_pos_in;
   logic [CFG_W-1:0] lit_pos_ff, lit_pos_in;
   logic [2:0]       fstat_ff, fstat_in;
   logic [1:0]       want_ff, want_in;
   logic             started_ff, started_in;

   // token and evaluate stage
   req_item_type     tok_ff, tok_in;
   logic             s1_pre_done_ff, s1_pre_done_in;
   logic             s1_cut_ff, s1_cut_in;
   logic             s1_dist_bad_ff, s1_dist_bad_in;
   logic [RUN_W-1:0] s1_len_ff, s1_len_in;
   logic [DIST_W-1:0] s1_dist_ff, s1_dist_in;
   logic [CFG_W-1:0] s1_pair_ff, s1_pair_in;
   logic [CFG_W-1:0] s1_lit_ff, s1_lit_in;
   logic [CFG_W-1:0] s1_map_inc_ff, s1_map_inc_in;

   // history and copy
   logic [7:0]       hist_mem [HISTORY_DEPTH];
   logic [AW-1:0]    hist_wr_ff, hist_wr_in;
   logic [AW-1:0]    src_ff, src_in;
   logic [RUN_W-1:0] rd_left_ff, rd_left_in;
   logic [RUN_W-1:0] wr_left_ff, wr_left_in;
   logic             pend_ff, pend_in;
   logic             fwd_ff, fwd_in;
   logic [7:0]       ram_q_ff;
   logic [7:0]       last_byte_ff, last_byte_in;
   logic             lit_emit_ff, lit_emit_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_data_ff, rsp_data_in;

   // evaluate stage signals
   logic [WIDE-1:0]  o_w, p_w, rem;
   logic [RUN_W-1:0] run_len, n_req;
   logic             fits;

   // commit signals
   logic [2:0]       fs_v;
   logic             use_tok, wrong, copy_go;
   logic [7:0]       bs_shift;
   logic [CFG_W-1:0] lim;
   logic [7:0]       adv_bsel;
   logic [1:0]       adv_want;
   logic [2:0]       adv_fs;
   logic [CFG_W-1:0] adv_map_pos;
   logic [PW-1:0]    src_calc;
   logic             wr_en;
   logic [7:0]       wr_data, copy_byte;
   logic             out_free;

   // ------------------------------------------------------------------ evaluate
   always_comb begin
      o_w     = WIDE'(osize_ff);
      p_w     = WIDE'(prod_ff);
      run_len = RUN_W'(tok_ff.token_data[15:12]) + RUN_W'(3);
      n_req   = (tok_ff.func == FN_WORD) ? run_len : RUN_W'(1);
      rem     = o_w - p_w;
      // a count that wraps short of the size never reaches it
      fits    = o_w < CNT_SPAN;

      s1_pre_done_in = p_w >= o_w;
      s1_cut_in      = fits && (rem <= WIDE'(n_req));
      s1_len_in      = s1_cut_in ? rem[RUN_W-1:0] : n_req;
      s1_dist_in     = DIST_W'(tok_ff.token_data[11:0]) + DIST_W'(1);
      s1_dist_bad_in = p_w < WIDE'(s1_dist_in);
      s1_pair_in     = (tok_ff.func == FN_WORD) ? pair_pos_ff + CFG_W'(2) : pair_pos_ff;
      s1_lit_in      = (tok_ff.func == FN_LIT) ? lit_pos_ff + CFG_W'(1) : lit_pos_ff;
      s1_map_inc_in  = map_pos_ff + CFG_W'(1);
      tok_in         = cmd.load ? req_payload : tok_ff;
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in;
      if (cmd.eval) begin
         s1_pre_done_ff <= s1_pre_done_in;
         s1_cut_ff      <= s1_cut_in;
         s1_len_ff      <= s1_len_in;
         s1_dist_ff     <= s1_dist_in;
         s1_dist_bad_ff <= s1_dist_bad_in;
         s1_pair_ff     <= s1_pair_in;
         s1_lit_ff      <= s1_lit_in;
         s1_map_inc_ff  <= s1_map_inc_in;
      end
   end

   // ------------------------------------------------------------------ commit
   always_comb begin
      fs_v = fstat_ff;
      if (fs_v == ST_RUN && s1_pre_done_ff) begin
         fs_v = ST_DONE;
      end
      wrong   = (fs_v == ST_RUN) && (tok_ff.func != want_ff);
      use_tok = (fs_v == ST_RUN) && (tok_ff.func == want_ff);
      copy_go = use_tok && (tok_ff.func == FN_WORD) && !s1_dist_bad_ff;

      // step to the next map bit
      bs_shift = bsel_ff >> 1;
      lim      = (s1_pair_ff < s1_lit_ff) ? s1_pair_ff : s1_lit_ff;
      if (bs_shift == 8'd0) begin
         adv_bsel    = 8'h80;
         adv_want    = FN_MAP;
         adv_map_pos = s1_map_inc_ff;
      end else begin
         adv_bsel    = bs_shift;
         adv_want    = ((map_bits_ff & bs_shift) != 8'd0) ? FN_LIT : FN_WORD;
         adv_map_pos = map_pos_ff;
      end
      if (bs_shift == 8'd0 && s1_map_inc_ff > lim) begin
         adv_fs = ST_OVERRUN;
      end else if (s1_cut_ff) begin
         adv_fs = ST_DONE;
      end else begin
         adv_fs = ST_RUN;
      end

      if ({1'b0, hist_wr_ff} < PW'(s1_dist_ff)) begin
         src_calc = {1'b0, hist_wr_ff} + DEPTH_P - PW'(s1_dist_ff);
      end else begin
         src_calc = {1'b0, hist_wr_ff} - PW'(s1_dist_ff);
      end
   end

   always_comb begin
      osize_in    = osize_ff;
      pair_off_in = pair_off_ff;
      lit_off_in  = lit_off_ff;
      prod_in     = prod_ff;
      map_bits_in = map_bits_ff;
      bsel_in     = bsel_ff;
      map_pos_in  = map_pos_ff;
      pair_pos_in = pair_pos_ff;
      lit_pos_in  = lit_pos_ff;
      fstat_in    = fstat_ff;
      want_in     = want_ff;
      started_in  = started_ff;
      lit_emit_in = lit_emit_ff;

      if (csr_write_en) begin
         case (csr_index)
            REG_OUTPUT_SIZE: begin
               osize_in = csr_wdata;
            end
            REG_PAIR_OFFSET: begin
               pair_off_in = csr_wdata;
               if (!started_ff) begin
                  pair_pos_in = csr_wdata;
               end
            end
            REG_LITERAL_OFFSET: begin
               lit_off_in = csr_wdata;
               if (!started_ff) begin
                  lit_pos_in = csr_wdata;
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.commit) begin
         fstat_in    = fs_v;
         lit_emit_in = use_tok && (tok_ff.func == FN_LIT);
         if (wrong) begin
            fstat_in = ST_WRONG;
         end else if (use_tok) begin
            started_in = 1'b1;
            case (tok_ff.func)
               FN_MAP: begin
                  map_bits_in = tok_ff.token_data[7:0];
                  bsel_in     = 8'h80;
                  want_in     = tok_ff.token_data[7] ? FN_LIT : FN_WORD;
               end
               FN_LIT: begin
                  prod_in    = prod_ff + COUNT_WIDTH'(s1_len_ff);
                  lit_pos_in = s1_lit_ff;
                  bsel_in    = adv_bsel;
                  want_in    = adv_want;
                  map_pos_in = adv_map_pos;
                  fstat_in   = adv_fs;
               end
               FN_WORD: begin
                  if (s1_dist_bad_ff) begin
                     fstat_in = ST_DIST;
                  end else begin
                     prod_in     = prod_ff + COUNT_WIDTH'(s1_len_ff);
                     pair_pos_in = s1_pair_ff;
                     bsel_in     = adv_bsel;
                     want_in     = adv_want;
                     map_pos_in  = adv_map_pos;
                     fstat_in    = adv_fs;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         osize_ff    <= '0;
         pair_off_ff <= CFG_W'(16);
         lit_off_ff  <= CFG_W'(16);
         prod_ff     <= '0;
         map_bits_ff <= '0;
         bsel_ff     <= 8'h80;
         map_pos_ff  <= CFG_W'(16);
         pair_pos_ff <= CFG_W'(16);
         lit_pos_ff  <= CFG_W'(16);
         fstat_ff    <= ST_RUN;
         want_ff     <= FN_MAP;
         started_ff  <= 1'b0;
         lit_emit_ff <= 1'b0;
      end else begin
         osize_ff    <= osize_in;
         pair_off_ff <= pair_off_in;
         lit_off_ff  <= lit_off_in;
         prod_ff     <= prod_in;
         map_bits_ff <= map_bits_in;
         bsel_ff     <= bsel_in;
         map_pos_ff  <= map_pos_in;
         pair_pos_ff <= pair_pos_in;
         lit_pos_ff  <= lit_pos_in;
         fstat_ff    <= fstat_in;
         want_ff     <= want_in;
         started_ff  <= started_in;
         lit_emit_ff <= lit_emit_in;
      end
   end

   // ------------------------------------------------------------------ history and copy
   // a read of the address written in the same cycle takes the byte just written
   assign copy_byte = fwd_ff ? last_byte_ff : ram_q_ff;

   always_comb begin
      wr_en   = (cmd.commit && use_tok && tok_ff.func == FN_LIT) || cmd.consume;
      wr_data = cmd.consume ? copy_byte : tok_ff.token_data[7:0];

      hist_wr_in   = hist_wr_ff;
      last_byte_in = last_byte_ff;
      if (wr_en) begin
         hist_wr_in   = (hist_wr_ff == LAST_ADDR) ? '0 : hist_wr_ff + AW'(1);
         last_byte_in = wr_data;
      end

      src_in     = src_ff;
      rd_left_in = rd_left_ff;
      wr_left_in = wr_left_ff;
      fwd_in     = fwd_ff;
      if (cmd.commit && copy_go) begin
         src_in     = src_calc[AW-1:0];
         rd_left_in = s1_len_ff;
         wr_left_in = s1_len_ff;
      end
      if (cmd.rd_issue) begin
         src_in     = (src_ff == LAST_ADDR) ? '0 : src_ff + AW'(1);
         rd_left_in = rd_left_ff - RUN_W'(1);
         fwd_in     = cmd.consume && (src_ff == hist_wr_ff);
      end
      if (cmd.consume) begin
         wr_left_in = wr_left_ff - RUN_W'(1);
      end

      if (cmd.rd_issue) begin
         pend_in = 1'b1;
      end else if (cmd.consume) begin
         pend_in = 1'b0;
      end else begin
         pend_in = pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[hist_wr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_issue) begin
         ram_q_ff <= hist_mem[src_ff];
      end
   end

   always_ff @(posedge clock) begin
      src_ff       <= src_in;
      fwd_ff       <= fwd_in;
      last_byte_ff <= last_byte_in;
      if (reset) begin
         hist_wr_ff <= '0;
         rd_left_ff <= '0;
         wr_left_ff <= '0;
         pend_ff    <= 1'b0;
      end else begin
         hist_wr_ff <= hist_wr_in;
         rd_left_ff <= rd_left_in;
         wr_left_ff <= wr_left_in;
         pend_ff    <= pend_in;
      end
   end

   // ------------------------------------------------------------------ output register
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.emit || cmd.consume) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.next_want   = (fstat_ff != ST_RUN) ? FN_NONE : want_ff;
         rsp_data_in.status      = fstat_ff;
         if (cmd.consume) begin
            rsp_data_in.out_byte    = copy_byte;
            rsp_data_in.byte_valid  = 1'b1;
            rsp_data_in.last_of_run = (wr_left_ff == RUN_W'(1));
         end else begin
            rsp_data_in.out_byte    = lit_emit_ff ? tok_ff.token_data[7:0] : 8'd0;
            rsp_data_in.byte_valid  = lit_emit_ff;
            rsp_data_in.last_of_run = 1'b1;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   assign sts.is_copy  = copy_go;
   assign sts.out_free = out_free;
   assign sts.pend     = pend_ff;
   assign sts.rd_more  = (rd_left_ff != '0);
   assign sts.wr_last  = (wr_left_ff == RUN_W'(1));

endmodule

// ===== verif/mio0_lz_checker.sv =====
// ----------------------------------------------------------------------------
// mio0_lz_checker
// Watches the token, result and register ports of the MIO0 decompressor,
// predicts the results of every accepted token and compares them in order.
// ----------------------------------------------------------------------------
module mio0_lz_checker
   import mio0_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  req_item_type     req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  rsp_item_type     rsp_payload,
   input  logic             csr_write_en,
   input  logic [1:0]       csr_index,
   input  logic [CFG_W-1:0] csr_wdata,
   output int               fail_count,
   output int               outstanding
);

   localparam int DEPTH = HIST_DEPTH_DEF;

   logic [CFG_W-1:0]           size_reg;
   logic [CFG_W-1:0]           pair_off_reg;
   logic [CFG_W-1:0]           lit_off_reg;
   logic [7:0]                 history_mem [DEPTH];
   int                         hist_wr;
   logic [COUNT_WIDTH_DEF-1:0] produced;
   logic [7:0]                 map_bits;
   logic [7:0]                 bit_sel;
   logic [23:0]                map_pos;
   logic [23:0]                pair_pos;
   logic [23:0]                lit_pos;
   logic [2:0]                 frame_st;
   logic [1:0]                 want;
   logic                       started;
   rsp_item_type               expected_out_q [$];

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      fail_count++;
   endtask

   task automatic compare_field(input string name, input int got, input int exp_val);
      if (got != exp_val) begin
         report_mismatch($sformatf("%s got %0h, predicted %0h", name, got, exp_val));
      end
   endtask

   task automatic reset_model();
      size_reg     = '0;
      pair_off_reg = 24'd16;
      lit_off_reg  = 24'd16;
      for (int i = 0; i < DEPTH; i++) begin
         history_mem[i] = 8'h00;
      end
      hist_wr  = 0;
      produced = '0;
      map_bits = 8'h00;
      bit_sel  = 8'h80;
      map_pos  = 24'h10;
      pair_pos = pair_off_reg;
      lit_pos  = lit_off_reg;
      frame_st = ST_RUN;
      want     = FN_MAP;
      started  = 1'b0;
   endtask

   task automatic apply_write(input logic [1:0] idx, input logic [CFG_W-1:0] data);
      case (idx)
         REG_OUTPUT_SIZE: size_reg = data;
         REG_PAIR_OFFSET: begin
            pair_off_reg = data;
            if (!started) pair_pos = data;
         end
         REG_LITERAL_OFFSET: begin
            lit_off_reg = data;
            if (!started) lit_pos = data;
         end
         default: ;
      endcase
   endtask

   task automatic store_byte(input logic [7:0] b);
      history_mem[hist_wr] = b;
      hist_wr = (hist_wr + 1) % DEPTH;
      produced++;
   endtask

   // move to the next map bit; a finished map byte checks the stream pointers
   task automatic step_map_bit();
      logic [23:0] lim;
      logic        overrun;
      overrun = 1'b0;
      bit_sel = bit_sel >> 1;
      if (bit_sel == 8'h00) begin
         lim     = (pair_pos < lit_pos) ? pair_pos : lit_pos;
         bit_sel = 8'h80;
         map_pos = map_pos + 24'd1;
         want    = FN_MAP;
         if (map_pos > lim) begin
            frame_st = ST_OVERRUN;
            overrun  = 1'b1;
         end
      end else begin
         want = ((map_bits & bit_sel) != 8'h00) ? FN_LIT : FN_WORD;
      end
      if (!overrun && produced >= size_reg) frame_st = ST_DONE;
   endtask

   task automatic decode_token(input req_item_type tok);
      logic [7:0]   run_byte [18];
      logic         run_valid [18];
      rsp_item_type r;
      int           n;
      int           i;
      int           len;
      int           back_dist;
      int           src;
      n = 0;
      if (frame_st == ST_RUN && produced >= size_reg) frame_st = ST_DONE;
      if (frame_st != ST_RUN) begin
         run_byte[0]  = 8'h00;
         run_valid[0] = 1'b0;
         n = 1;
      end else if (tok.func != want) begin
         frame_st     = ST_WRONG;
         run_byte[0]  = 8'h00;
         run_valid[0] = 1'b0;
         n = 1;
      end else begin
         started = 1'b1;
         case (tok.func)
            FN_MAP: begin
               map_bits     = tok.token_data[7:0];
               bit_sel      = 8'h80;
               want         = map_bits[7] ? FN_LIT : FN_WORD;
               run_byte[0]  = 8'h00;
               run_valid[0] = 1'b0;
               n = 1;
            end
            FN_LIT: begin
               store_byte(tok.token_data[7:0]);
               lit_pos      = lit_pos + 24'd1;
               run_byte[0]  = tok.token_data[7:0];
               run_valid[0] = 1'b1;
               n = 1;
               step_map_bit();
            end
            default: begin
               len       = int'(tok.token_data[15:12]) + 3;
               back_dist = int'(tok.token_data[11:0]) + 1;
               if (int'(produced) < back_dist) begin
                  frame_st     = ST_DIST;
                  run_byte[0]  = 8'h00;
                  run_valid[0] = 1'b0;
                  n = 1;
               end else begin
                  for (i = 0; i < len; i++) begin
                     src = (hist_wr + DEPTH - back_dist) % DEPTH;
                     run_byte[n]  = history_mem[src];
                     run_valid[n] = 1'b1;
                     n++;
                     store_byte(history_mem[src]);
                     // the run is cut once the frame size is reached
                     if (produced >= size_reg) break;
                  end
                  pair_pos = pair_pos + 24'd2;
                  step_map_bit();
               end
            end
         endcase
      end
      for (i = 0; i < n; i++) begin
         r.out_byte    = run_byte[i];
         r.byte_valid  = run_valid[i];
         r.last_of_run = (i == n - 1);
         r.next_want   = (frame_st != ST_RUN) ? FN_NONE : want;
         r.status      = frame_st;
         expected_out_q.push_back(r);
      end
   endtask

   task automatic check_result(input rsp_item_type got);
      rsp_item_type exp_item;
      if (expected_out_q.size() == 0) begin
         report_mismatch($sformatf("result %0h with no item waiting", got));
      end else begin
         exp_item = expected_out_q.pop_front();
         compare_field("out_byte", got.out_byte, exp_item.out_byte);
         compare_field("byte_valid", got.byte_valid, exp_item.byte_valid);
         compare_field("last_of_run", got.last_of_run, exp_item.last_of_run);
         compare_field("next_want", got.next_want, exp_item.next_want);
         compare_field("status", got.status, exp_item.status);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         reset_model();
         expected_out_q.delete();
         outstanding <= 0;
      end else begin
         // results first: nothing accepted at this edge can answer already
         if (rsp_valid && rsp_ready) check_result(rsp_payload);
         if (csr_write_en) apply_write(csr_index, csr_wdata);
         if (req_valid && req_ready) decode_token(req_payload);
         outstanding <= expected_out_q.size();
      end
   end

endmodule

// ===== verif/tb_mio0_lz_decompressor.sv =====
// ----------------------------------------------------------------------------
// tb_mio0_lz_decompressor
// Feeds one long MIO0 frame of map, literal and back-reference tokens with
// bursty input and a stalling result side, rewrites the registers between
// phases and ends the frame by size, empty size, wrong kind, bad distance or map overrun.
// ----------------------------------------------------------------------------
module tb_mio0_lz_decompressor;
   import mio0_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   typedef enum int {
      FINISH_BY_SIZE,
      FINISH_BY_EMPTY_SIZE,
      FINISH_BY_WRONG_KIND,
      FINISH_BY_BAD_DISTANCE,
      FINISH_BY_OVERRUN
   } finish_mode_type;

   typedef enum int {
      RX_OPEN,
      RX_COIN,
      RX_EVERY_FOURTH,
      RX_MOSTLY
   } rx_mode_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_item_type     req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_item_type     rsp_payload;
   logic             csr_write_en = 1'b0;
   logic [1:0]       csr_index = REG_OUTPUT_SIZE;
   logic [CFG_W-1:0] csr_wdata = '0;

   int               fail_count;
   int               outstanding;
   int               cycle_count = 0;

   req_item_type     token_q [$];
   int               pushed_count = 0;
   int               accepted_count = 0;
   int               burst_left = 0;
   int               gap_left = 0;
   rx_mode_type      rx_mode = RX_OPEN;
   int               rx_left = 0;
   int               rx_tick = 0;

   finish_mode_type  finish_mode;
   bit               overrun_mode;
   int unsigned      gen_count = 0;   // bytes the frame has produced so far
   int               lit_slack = 0;   // literal pointer minus map pointer
   int               size_target;
   int               bad_dist;

   mio0_lz_decompressor i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   mio0_lz_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .fail_count   (fail_count),
      .outstanding  (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("mio0_lz_decompressor test failed");
         $finish;
      end
   end

   // token sender: bursts of random length separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_valid && req_ready) accepted_count <= accepted_count + 1;
         if (!req_valid || req_ready) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
            if (gap_left > 0 || token_q.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_valid <= 1'b0;
            end else begin
               req_payload <= token_q.pop_front();
               req_valid   <= 1'b1;
               burst_left--;
            end
         end
      end
   end

   // result side stalls on a pattern that is picked anew at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rx_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 120);
         end
         rx_left--;
         rx_tick++;
         case (rx_mode)
            RX_OPEN:         rsp_ready <= 1'b1;
            RX_COIN:         rsp_ready <= ($urandom_range(0, 1) == 0);
            RX_EVERY_FOURTH: rsp_ready <= (rx_tick % 4 == 0);
            default:         rsp_ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
   endtask

   task automatic csr_release();
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic wait_idle();
      while (accepted_count != pushed_count || outstanding != 0) @(posedge clock);
   endtask

   task automatic push_token(input logic [1:0] func, input logic [15:0] data);
      req_item_type tok;
      tok.func       = func;
      tok.token_data = data;
      token_q.push_back(tok);
      pushed_count++;
   endtask

   task automatic send_literal(input logic [15:0] data);
      push_token(FN_LIT, data);
      gen_count++;
      lit_slack++;
   endtask

   task automatic send_word(input int len_code, input int distance);
      push_token(FN_WORD, {4'(len_code), 12'(distance - 1)});
      gen_count += len_code + 3;
   endtask

   task automatic send_map_byte(input logic [15:0] data);
      push_token(FN_MAP, data);
      lit_slack--;
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [CFG_W-1:0] pick_offset();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return '1;
         default: return CFG_W'($urandom);
      endcase
   endfunction

   // map byte for the random part; in overrun runs the literal pointer is
   // kept at most 10 bytes ahead of the map pointer so the overrun comes on cue
   function automatic logic [7:0] pick_map();
      logic [7:0] m;
      case ($urandom_range(0, 7))
         0:       m = 8'h00;
         1:       m = 8'hFF;
         default: m = 8'($urandom);
      endcase
      if (overrun_mode) begin
         if (lit_slack + $countones(m) - 1 > 10) m = 8'h00;
         else if (lit_slack + $countones(m) - 1 < 0) m[0] = 1'b1;
      end
      return m;
   endfunction

   task automatic send_random_word();
      int reach;
      int len_code;
      int distance;
      reach    = (gen_count < HIST_DEPTH_DEF) ? gen_count : HIST_DEPTH_DEF;
      len_code = $urandom_range(0, 1) ? 15 : $urandom_range(0, 15);
      case ($urandom_range(0, 3))
         0:       distance = 1;
         1:       distance = $urandom_range(1, (reach < 24) ? reach : 24);
         2:       distance = reach;
         default: distance = $urandom_range(1, reach);
      endcase
      send_word(len_code, distance);
   endtask

   task automatic send_group(input logic [7:0] bits);
      send_map_byte({8'($urandom), bits});
      for (int i = 7; i >= 0; i--) begin
         if (bits[i]) send_literal({8'($urandom), pick_byte()});
         else send_random_word();
      end
   endtask

   initial begin
      finish_mode  = finish_mode_type'($urandom_range(0, 4));
      overrun_mode = (finish_mode == FINISH_BY_OVERRUN);
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // offsets written twice before the first token: the second load counts
      csr_write(REG_PAIR_OFFSET, pick_offset());
      csr_write(REG_LITERAL_OFFSET, pick_offset());
      csr_write(REG_OUTPUT_SIZE, '1);
      if (overrun_mode) begin
         csr_write(REG_PAIR_OFFSET, CFG_W'($urandom_range(24'h100000, 24'hF00000)));
         csr_write(REG_LITERAL_OFFSET, CFG_W'($urandom_range(10, 24)));
      end else begin
         csr_write(REG_PAIR_OFFSET, CFG_W'($urandom_range(24'h1000, 24'hF00000)));
         csr_write(REG_LITERAL_OFFSET, CFG_W'($urandom_range(24'h1000, 24'hF00000)));
      end
      csr_release();
      lit_slack = int'(csr_wdata) - 16;

      // all-literal map with extreme token data
      send_map_byte(16'hFFFF);
      send_literal(16'h0000);
      send_literal(16'hFFFF);
      send_literal(16'h00FF);
      send_literal(16'hFF00);
      repeat (4) send_literal({8'($urandom), pick_byte()});
      // all-reference map: overlapping copies, shortest and longest runs,
      // distance back to the very first byte
      send_map_byte(16'hFF00);
      send_word(0, 1);
      send_word(15, 1);
      send_word(15, 2);
      send_word(0, gen_count);
      send_word(15, gen_count);
      send_word(7, 3);
      send_word(3, 5);
      send_word(15, gen_count);
      send_group(8'hAA);

      for (int phase = 0; phase < 4; phase++) begin
         while (pushed_count < 27 + 64 * (phase + 1)) send_group(pick_map());
         wait_idle();
         // late offset writes only change the registers
         csr_write(REG_OUTPUT_SIZE,
                   $urandom_range(0, 1) ? '1 : CFG_W'($urandom_range(24'h800000, 24'hFFFFFF)));
         csr_write(REG_PAIR_OFFSET, pick_offset());
         csr_write(REG_LITERAL_OFFSET, pick_offset());
         csr_release();
      end

      if (finish_mode == FINISH_BY_BAD_DISTANCE && gen_count >= HIST_DEPTH_DEF) begin
         finish_mode = FINISH_BY_WRONG_KIND;
      end
      case (finish_mode)
         FINISH_BY_SIZE: begin
            size_target = gen_count + $urandom_range(1, 40);
            csr_write(REG_OUTPUT_SIZE, CFG_W'(size_target));
            csr_release();
            while (gen_count < size_target) send_group(pick_map());
         end
         FINISH_BY_EMPTY_SIZE: begin
            csr_write(REG_OUTPUT_SIZE, '0);
            csr_release();
         end
         FINISH_BY_WRONG_KIND: begin
            case ($urandom_range(0, 2))
               0:       push_token(FN_LIT, 16'($urandom));
               1:       push_token(FN_WORD, 16'($urandom));
               default: push_token(FN_NONE, 16'($urandom));
            endcase
         end
         FINISH_BY_BAD_DISTANCE: begin
            send_map_byte({8'($urandom), 8'h00});
            bad_dist = $urandom_range(gen_count + 1, HIST_DEPTH_DEF);
            send_word($urandom_range(0, 15), bad_dist);
         end
         default: begin
            while (lit_slack >= 0) send_group(8'h00);
         end
      endcase
      // the stopped frame answers every further token the same way
      repeat (5) push_token(2'($urandom_range(0, 3)), 16'($urandom));

      wait_idle();
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("mio0_lz_decompressor test passed");
      end else begin
         $display("mio0_lz_decompressor test failed");
      end
      $finish;
   end

endmodule
